// ----- rtl/packet_loss_and_rate_monitor_core_defines.svh -----
// ----------------------------------------------------------------------------
// packet loss and rate monitor assertion macros
// shared property forms for the monitor's checks
// ----------------------------------------------------------------------------
`ifndef PACKET_LOSS_AND_RATE_MONITOR_CORE_DEFINES_SVH
`define PACKET_LOSS_AND_RATE_MONITOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PLRM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plrm same-cycle check failed");

// next-cycle implication, disabled in reset
`define PLRM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plrm next-cycle check failed");

`endif

// ----- rtl/plrm_pkg.sv -----
// ----------------------------------------------------------------------------
// plrm_pkg
// types, codes and reset values shared by the packet loss and rate monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plrm_pkg;

    localparam int NUM_STREAMS_DEF = 3;

    localparam int ACT_W    = 2;
    localparam int STREAM_W = 2;
    localparam int SEQ_W    = 32;
    localparam int CNT_W    = 32;
    localparam int RATE_W   = 16;
    localparam int KIND_W   = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = KIND_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SEQ_W-1:0]  MAX_GAP_RST   = 32'd1000;
    localparam logic [RATE_W-1:0] WINDOW_MS_RST = 16'd1000;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_GAP   = 1'b0;
    localparam logic REG_WINDOW_MS = 1'b1;

    localparam logic [ACT_W-1:0] ACT_PACKET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [KIND_W-1:0] GAP_FIRST    = 3'd0;
    localparam logic [KIND_W-1:0] GAP_IN_ORDER = 3'd1;
    localparam logic [KIND_W-1:0] GAP_LOSS     = 3'd2;
    localparam logic [KIND_W-1:0] GAP_REGRESS  = 3'd3;
    localparam logic [KIND_W-1:0] GAP_RESYNC   = 3'd4;
    localparam logic [KIND_W-1:0] GAP_NONE     = 3'd5;

    typedef struct packed {
        logic fire;
        logic pkt;
        logic tick;
        logic clr;
    } t_item_ctl;

    typedef struct packed {
        logic [SEQ_W-1:0]  max_gap;
        logic [RATE_W-1:0] window_ms;
    } t_cfg;

endpackage

// ----- rtl/plrm_cfg.sv -----
// ----------------------------------------------------------------------------
// plrm_cfg
// apb register file holding max_gap and window_ms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plrm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [plrm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [plrm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output plrm_pkg::t_cfg                  o_cfg
);
    import plrm_pkg::*;

    logic [SEQ_W-1:0]  r_max_gap;
    logic [RATE_W-1:0] r_window_ms;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap   <= MAX_GAP_RST;
            r_window_ms <= WINDOW_MS_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_MAX_GAP) begin
                r_max_gap <= pwdata[SEQ_W-1:0];
            end else begin
                r_window_ms <= pwdata[RATE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WINDOW_MS) begin
            prdata = {{(APB_DATA_W-RATE_W){1'b0}}, r_window_ms};
        end else begin
            prdata = r_max_gap;
        end
    end

    assign o_cfg.max_gap   = r_max_gap;
    assign o_cfg.window_ms = r_window_ms;

endmodule

// ----- rtl/plrm_win.sv -----
// ----------------------------------------------------------------------------
// plrm_win
// millisecond tick counter that closes the receive rate window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrm_win (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  plrm_pkg::t_item_ctl         i_ctl,
    input  logic [plrm_pkg::RATE_W-1:0] i_window_ms,
    output logic                        o_closed
);
    import plrm_pkg::*;

    logic [RATE_W-1:0] r_ms;
    logic [RATE_W-1:0] n_ms;
    logic [RATE_W:0]   w_next;

    // a zero window length closes on every tick, same as one
    assign w_next   = {1'b0, r_ms} + {{RATE_W{1'b0}}, 1'b1};
    assign o_closed = i_ctl.tick && !(w_next < {1'b0, i_window_ms});

    always_comb begin
        n_ms = r_ms;
        if (i_ctl.fire) begin
            if (i_ctl.clr || o_closed) begin
                n_ms = '0;
            end else if (i_ctl.tick) begin
                n_ms = w_next[RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
        end else begin
            r_ms <= n_ms;
        end
    end

endmodule

// ----- rtl/plrm_stats.sv -----
// ----------------------------------------------------------------------------
// plrm_stats
// per-stream sequence tracking, packet counters and latched rates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrm_stats #(
    parameter int NUM_STREAMS = plrm_pkg::NUM_STREAMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plrm_pkg::t_item_ctl           i_ctl,
    input  logic                          i_closed,
    input  logic [plrm_pkg::SEQ_W-1:0]    i_max_gap,
    input  logic [plrm_pkg::STREAM_W-1:0] i_stream,
    input  logic [plrm_pkg::SEQ_W-1:0]    i_seq,
    output logic [plrm_pkg::CNT_W-1:0]    o_rx_total,
    output logic [plrm_pkg::CNT_W-1:0]    o_missed_total,
    output logic [plrm_pkg::RATE_W-1:0]   o_rate,
    output logic [plrm_pkg::KIND_W-1:0]   o_gap_kind
);
    import plrm_pkg::*;

    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    logic              r_seen   [NUM_STREAMS];
    logic [SEQ_W-1:0]  r_last   [NUM_STREAMS];
    logic [CNT_W-1:0]  r_missed [NUM_STREAMS];
    logic [CNT_W-1:0]  r_rx     [NUM_STREAMS];
    logic [RATE_W-1:0] r_win    [NUM_STREAMS];
    logic [RATE_W-1:0] r_rate   [NUM_STREAMS];

    logic              w_valid;
    logic [IDX_W-1:0]  w_idx;
    logic              w_pkt;
    logic              w_close;
    logic              w_clr;
    logic              w_seen;
    logic [SEQ_W-1:0]  w_last;
    logic [CNT_W-1:0]  w_missed;
    logic [CNT_W-1:0]  w_rx;
    logic [RATE_W-1:0] w_win;
    logic [RATE_W-1:0] w_rate;
    logic [SEQ_W-1:0]  w_delta;
    logic [SEQ_W-1:0]  w_lost;
    logic [CNT_W-1:0]  n_missed;
    logic [CNT_W-1:0]  n_rx;
    logic [RATE_W-1:0] n_win;
    logic [KIND_W-1:0] w_kind;

    assign w_valid = 32'(i_stream) < 32'(NUM_STREAMS);
    assign w_idx   = IDX_W'(i_stream);
    assign w_pkt   = i_ctl.fire && i_ctl.pkt && w_valid;
    assign w_close = i_ctl.fire && i_ctl.tick && i_closed;
    assign w_clr   = i_ctl.fire && i_ctl.clr;

    // an out-of-range stream reads as all zero
    assign w_seen   = w_valid ? r_seen[w_idx]   : 1'b0;
    assign w_last   = w_valid ? r_last[w_idx]   : '0;
    assign w_missed = w_valid ? r_missed[w_idx] : '0;
    assign w_rx     = w_valid ? r_rx[w_idx]     : '0;
    assign w_win    = w_valid ? r_win[w_idx]    : '0;
    assign w_rate   = w_valid ? r_rate[w_idx]   : '0;

    assign w_delta = i_seq - w_last;
    assign w_lost  = w_delta - {{(SEQ_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_missed = w_missed;
        if (!i_ctl.pkt || !w_valid) begin
            w_kind = GAP_NONE;
        end else if (!w_seen) begin
            w_kind = GAP_FIRST;
        end else if (i_seq <= w_last) begin
            w_kind = GAP_REGRESS;
        end else if (w_delta > i_max_gap) begin
            w_kind = GAP_RESYNC;
        end else if (w_lost != '0) begin
            w_kind   = GAP_LOSS;
            n_missed = w_missed + w_lost;
        end else begin
            w_kind = GAP_IN_ORDER;
        end
    end

    assign n_rx  = w_rx + {{(CNT_W-1){1'b0}}, 1'b1};
    // window count saturates
    assign n_win = (w_win == '1) ? w_win : w_win + {{(RATE_W-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                r_seen[i]   <= 1'b0;
                r_last[i]   <= '0;
                r_missed[i] <= '0;
                r_rx[i]     <= '0;
                r_win[i]    <= '0;
                r_rate[i]   <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                if (w_close) begin
                    r_rate[i] <= r_win[i];
                    r_win[i]  <= '0;
                end
                if (w_pkt && w_idx == IDX_W'(i)) begin
                    r_seen[i]   <= 1'b1;
                    r_last[i]   <= i_seq;
                    r_missed[i] <= n_missed;
                    r_rx[i]     <= n_rx;
                    r_win[i]    <= n_win;
                end
            end
        end
    end

    // result shows the statistics after this word is applied
    always_comb begin
        o_gap_kind = w_kind;
        if (i_ctl.clr) begin
            o_rx_total     = '0;
            o_missed_total = '0;
            o_rate         = '0;
        end else if (i_ctl.pkt && w_valid) begin
            o_rx_total     = n_rx;
            o_missed_total = n_missed;
            o_rate         = w_rate;
        end else begin
            o_rx_total     = w_rx;
            o_missed_total = w_missed;
            o_rate         = (i_ctl.tick && i_closed) ? w_win : w_rate;
        end
    end

endmodule

// ----- rtl/packet_loss_and_rate_monitor_core.sv -----
// Packet loss and rate monitor: takes one word per clock on the slave stream unless
// stalled and returns exactly one result word per input, through the input register and
// then the result register. The per-stream read-modify-write of sequence, loss and window
// counters finishes in the single update stage between those registers, so the sustained
// rate is one word per cycle; a stalled result register holds back the input side.
// A packet word updates its stream's state, a tick word advances the rate window and, every
// window_ms ticks, latches all window counts as rates, and a clear word zeroes all statistics.
// Registers: max_gap at byte address 0, window_ms at byte address 4.
`timescale 1ns / 1ps
`include "packet_loss_and_rate_monitor_core_defines.svh"

// ----------------------------------------------------------------------------
// packet_loss_and_rate_monitor_core
// top level: stream handshake, input and result registers, apb port
// ----------------------------------------------------------------------------
module packet_loss_and_rate_monitor_core #(
    parameter int NUM_STREAMS = plrm_pkg::NUM_STREAMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] stream, [33:2] seq, [39:34] zero
    input  logic [plrm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [plrm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] stream_out, [33:2] rx_total, [65:34] missed_total, [81:66] rate, [87:82] zero
    output logic [plrm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [2:0] gap_kind, [3] window_closed
    output logic [plrm_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plrm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [plrm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [plrm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import plrm_pkg::*;

    t_cfg              w_cfg;
    t_item_ctl         w_ctl;
    logic              w_adv;
    logic              w_in_take;
    logic              w_closed;
    logic [CNT_W-1:0]  w_rx_total;
    logic [CNT_W-1:0]  w_missed_total;
    logic [RATE_W-1:0] w_rate;
    logic [KIND_W-1:0] w_gap_kind;

    logic                r_in_valid;
    logic [ACT_W-1:0]    r_in_action;
    logic [STREAM_W-1:0] r_in_stream;
    logic [SEQ_W-1:0]    r_in_seq;

    logic                r_out_valid;
    logic [STREAM_W-1:0] r_out_stream;
    logic [CNT_W-1:0]    r_out_rx;
    logic [CNT_W-1:0]    r_out_missed;
    logic [RATE_W-1:0]   r_out_rate;
    logic [KIND_W-1:0]   r_out_kind;
    logic                r_out_closed;

    plrm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // update stage moves when the result register is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign w_ctl.fire = w_adv;
    assign w_ctl.pkt  = (r_in_action == ACT_PACKET);
    assign w_ctl.tick = (r_in_action == ACT_TICK);
    assign w_ctl.clr  = (r_in_action == ACT_CLEAR);

    plrm_win u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_window_ms (w_cfg.window_ms),
        .o_closed    (w_closed)
    );

    plrm_stats #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_closed       (w_closed),
        .i_max_gap      (w_cfg.max_gap),
        .i_stream       (r_in_stream),
        .i_seq          (r_in_seq),
        .o_rx_total     (w_rx_total),
        .o_missed_total (w_missed_total),
        .o_rate         (w_rate),
        .o_gap_kind     (w_gap_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action <= s_axis_tuser[ACT_W-1:0];
            r_in_stream <= s_axis_tdata[STREAM_W-1:0];
            r_in_seq    <= s_axis_tdata[STREAM_W+SEQ_W-1:STREAM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_stream <= r_in_stream;
            r_out_rx     <= w_rx_total;
            r_out_missed <= w_missed_total;
            r_out_rate   <= w_rate;
            r_out_kind   <= w_gap_kind;
            r_out_closed <= w_closed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-STREAM_W-2*CNT_W-RATE_W){1'b0}},
                            r_out_rate, r_out_missed, r_out_rx, r_out_stream};
    assign m_axis_tuser  = {r_out_closed, r_out_kind};

    `PLRM_ASSERT_NXT(a_clear_zeroes, i_clk, i_rst_n, w_adv && w_ctl.clr,
        r_out_rx == '0 && r_out_missed == '0 && r_out_rate == '0)
    `PLRM_ASSERT_NXT(a_kind_none, i_clk, i_rst_n, w_adv && !w_ctl.pkt,
        r_out_kind == GAP_NONE)
    `PLRM_ASSERT_NXT(a_close_on_tick, i_clk, i_rst_n, w_adv && !w_ctl.tick,
        !r_out_closed)
    `PLRM_ASSERT_NXT(a_no_drop, i_clk, i_rst_n, r_in_valid && r_out_valid && !m_axis_tready,
        r_in_valid && r_out_valid)

endmodule

// ----- verif/tb_packet_loss_and_rate_monitor_core.sv -----
// ----------------------------------------------------------------------------
// tb_packet_loss_and_rate_monitor_core
// stream-level check of the packet loss and rate monitor: every word sent is
// run through a local model of the per-stream sequence tracking and the
// tick-driven rate window, and each result word is compared with it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packet_loss_and_rate_monitor_core;

    import plrm_pkg::*;

    localparam int NS         = NUM_STREAMS_DEF;
    localparam int QUIET_MAX  = 1000;
    localparam int MAX_REPORT = 10;

    // action code the block leaves undefined, and a stream index past the last
    localparam logic [ACT_W-1:0]    ACT_RESERVED  = 2'd3;
    localparam logic [STREAM_W-1:0] STREAM_UNUSED = 2'd3;

    typedef struct packed {
        logic [STREAM_W-1:0] strm;
        logic [CNT_W-1:0]    rx;
        logic [CNT_W-1:0]    missed;
        logic [RATE_W-1:0]   rate;
        logic [KIND_W-1:0]   kind;
        logic                closed;
    } t_link_stats;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    packet_loss_and_rate_monitor_core #(.NUM_STREAMS(NS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the monitor state
    logic [SEQ_W-1:0]  cfg_max_gap;
    logic [RATE_W-1:0] cfg_window;
    logic              trk_seen   [NS];
    logic [SEQ_W-1:0]  trk_last   [NS];
    logic [CNT_W-1:0]  trk_missed [NS];
    logic [CNT_W-1:0]  trk_rx     [NS];
    logic [RATE_W-1:0] trk_win    [NS];
    logic [RATE_W-1:0] trk_rate   [NS];
    logic [RATE_W-1:0] trk_ms;

    t_link_stats stats_due[$];

    bit idle_on = 1'b0;
    int rd_hold = 0;
    int quiet = 0;
    int n_errors = 0;
    int n_words = 0;
    int n_results = 0;
    int n_closes = 0;
    int kind_hits [6];

    function automatic void wipe_stats();
        for (int i = 0; i < NS; i++) begin
            trk_seen[i]   = 1'b0;
            trk_last[i]   = '0;
            trk_missed[i] = '0;
            trk_rx[i]     = '0;
            trk_win[i]    = '0;
            trk_rate[i]   = '0;
        end
        trk_ms = '0;
    endfunction

    function automatic t_link_stats apply_word(input logic [ACT_W-1:0] act,
                                               input logic [STREAM_W-1:0] strm,
                                               input logic [SEQ_W-1:0] seq);
        t_link_stats r;
        logic [SEQ_W-1:0] delta;
        logic [RATE_W:0]  next_ms;
        r = '0;
        r.strm = strm;
        r.kind = GAP_NONE;
        case (act)
            ACT_PACKET: begin
                if (strm < NS) begin
                    trk_rx[strm] = trk_rx[strm] + 1;
                    if (trk_win[strm] != 16'hFFFF)
                        trk_win[strm] = trk_win[strm] + 16'd1;
                    if (!trk_seen[strm]) begin
                        trk_seen[strm] = 1'b1;
                        r.kind = GAP_FIRST;
                    end else if (seq <= trk_last[strm]) begin
                        r.kind = GAP_REGRESS;
                    end else begin
                        delta = seq - trk_last[strm];
                        if (delta > cfg_max_gap) begin
                            r.kind = GAP_RESYNC;
                        end else if (delta > 1) begin
                            trk_missed[strm] = trk_missed[strm] + delta - 1;
                            r.kind = GAP_LOSS;
                        end else begin
                            r.kind = GAP_IN_ORDER;
                        end
                    end
                    trk_last[strm] = seq;
                end
            end
            ACT_TICK: begin
                next_ms = {1'b0, trk_ms} + 17'd1;
                // a zero window length behaves like one
                if (next_ms < cfg_window) begin
                    trk_ms = next_ms[RATE_W-1:0];
                end else begin
                    for (int i = 0; i < NS; i++) begin
                        trk_rate[i] = trk_win[i];
                        trk_win[i]  = '0;
                    end
                    trk_ms = '0;
                    r.closed = 1'b1;
                end
            end
            ACT_CLEAR: wipe_stats();
            default: ;
        endcase
        if (strm < NS) begin
            r.rx     = trk_rx[strm];
            r.missed = trk_missed[strm];
            r.rate   = trk_rate[strm];
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // sends one word; tvalid is left high so back-to-back words need no gap
    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic [STREAM_W-1:0] strm,
                             input logic [SEQ_W-1:0] seq);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, seq, strm};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        stats_due.push_back(apply_word(act, strm, seq));
        n_words++;
    endtask

    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        while (stats_due.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // write, then read back; only called while the stream side is idle
    task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_MAX_GAP)
            cfg_max_gap = val;
        else
            cfg_window = val[RATE_W-1:0];
        want = (idx == REG_MAX_GAP) ? cfg_max_gap : {16'd0, cfg_window};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want)
            flag_error($sformatf("register %0d read exp %h got %h", idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [SEQ_W-1:0] gap_lim, input logic [RATE_W-1:0] win);
        settle(4);
        reg_write(REG_MAX_GAP, gap_lim);
        reg_write(REG_WINDOW_MS, {16'd0, win});
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (rd_hold > 0) begin
            rd_hold       <= rd_hold - 1;
            m_axis_tready <= (rd_hold == 1);
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rd_hold       <= $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_link_stats got;
        t_link_stats want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.strm   = m_axis_tdata[1:0];
            got.rx     = m_axis_tdata[33:2];
            got.missed = m_axis_tdata[65:34];
            got.rate   = m_axis_tdata[81:66];
            got.kind   = m_axis_tuser[2:0];
            got.closed = m_axis_tuser[3];
            n_results++;
            if (stats_due.size() == 0) begin
                flag_error("result word with nothing expected");
            end else begin
                want = stats_due.pop_front();
                if (got !== want)
                    flag_error($sformatf({"exp strm %0d rx %h miss %h rate %h kind %0d cl %b",
                        " | got strm %0d rx %h miss %h rate %h kind %0d cl %b"},
                        want.strm, want.rx, want.missed, want.rate, want.kind, want.closed,
                        got.strm, got.rx, got.missed, got.rate, got.kind, got.closed));
                if (want.closed)
                    n_closes++;
                if (want.kind <= GAP_NONE)
                    kind_hits[want.kind]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable && pready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("timeout: no handshake for %0d cycles", QUIET_MAX);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // every loss classification, the reserved action, the unused stream,
    // a clear, and a window closing on its third tick
    task automatic test_gap_kinds();
        set_regs(32'd5, 16'd3);
        send_word(ACT_PACKET, 2'd0, 32'd0);
        send_word(ACT_PACKET, 2'd0, 32'd1);
        send_word(ACT_PACKET, 2'd0, 32'd4);
        send_word(ACT_PACKET, 2'd0, 32'd9);
        send_word(ACT_PACKET, 2'd0, 32'd15);
        send_word(ACT_PACKET, 2'd0, 32'd15);
        send_word(ACT_PACKET, 2'd0, 32'd3);
        send_word(ACT_PACKET, 2'd1, 32'hFFFF_FFFF);
        send_word(ACT_PACKET, 2'd1, 32'hFFFF_FFFF);
        send_word(ACT_PACKET, 2'd1, 32'd0);
        send_word(ACT_PACKET, 2'd2, 32'd7);
        send_word(ACT_PACKET, STREAM_UNUSED, 32'd5);
        send_word(ACT_TICK, STREAM_UNUSED, 32'hFFFF_FFFF);
        send_word(ACT_TICK, 2'd0, 32'd0);
        send_word(ACT_TICK, 2'd2, 32'd0);
        send_word(ACT_RESERVED, 2'd0, 32'hA5A5_5A5A);
        send_word(ACT_PACKET, 2'd0, 32'd4);
        send_word(ACT_CLEAR, 2'd1, 32'd0);
        send_word(ACT_PACKET, 2'd1, 32'd0);
        send_word(ACT_TICK, STREAM_UNUSED, 32'd0);
        send_word(ACT_CLEAR, STREAM_UNUSED, 32'h5A5A_A5A5);
    endtask

    // zero gap limit and window, widest gap limit with a single loss of
    // 32'hFFFFFFFE, and a window shortened in the middle
    task automatic test_register_extremes();
        set_regs(32'd0, 16'd0);
        send_word(ACT_PACKET, 2'd0, 32'd10);
        send_word(ACT_PACKET, 2'd0, 32'd11);
        send_word(ACT_TICK, 2'd0, 32'd0);
        send_word(ACT_TICK, 2'd1, 32'd0);
        set_regs(32'hFFFF_FFFF, 16'hFFFF);
        send_word(ACT_PACKET, 2'd2, 32'd0);
        send_word(ACT_PACKET, 2'd2, 32'hFFFF_FFFF);
        send_word(ACT_PACKET, 2'd2, 32'd0);
        send_word(ACT_PACKET, 2'd2, 32'hFFFF_FFFF);
        send_word(ACT_TICK, 2'd2, 32'd0);
        set_regs(32'hFFFF_FFFF, 16'd10);
        repeat (5) send_word(ACT_TICK, 2'd1, 32'd0);
        set_regs(32'd1000, 16'd3);
        send_word(ACT_TICK, 2'd1, 32'd0);
    endtask

    // a long run of packets inside one window, then a one-tick window latches it
    task automatic test_window_latch();
        set_regs(32'd1000, 16'hFFFF);
        send_word(ACT_CLEAR, 2'd0, 32'd0);
        for (int i = 0; i < 60; i++)
            send_word(ACT_PACKET, 2'd0, SEQ_W'(i));
        set_regs(32'd1000, 16'd1);
        send_word(ACT_TICK, 2'd0, 32'd0);
        send_word(ACT_PACKET, 2'd0, 32'd60);
    endtask

    // mostly well-formed per-stream sequences with random content,
    // mixed with ticks, clears, jumps and ignored words
    task automatic test_random_traffic(input int count, input logic [SEQ_W-1:0] gap_lim,
                                       input logic [RATE_W-1:0] win, input bit stalls);
        int pick;
        logic [STREAM_W-1:0] s;
        logic [SEQ_W-1:0] base;
        set_regs(gap_lim, win);
        idle_on = stalls;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            s = STREAM_W'($urandom_range(0, NS - 1));
            base = trk_last[s];
            if (pick < 50)
                send_word(ACT_PACKET, s, base + 1);
            else if (pick < 66)
                send_word(ACT_PACKET, s, base + $urandom_range(2, 40));
            else if (pick < 70)
                send_word(ACT_PACKET, s, $urandom);
            else if (pick < 74)
                send_word(ACT_PACKET, s, base - $urandom_range(0, 3));
            else if (pick < 76)
                send_word(ACT_PACKET, s, base + $urandom);
            else if (pick < 93)
                send_word(ACT_TICK, STREAM_W'($urandom_range(0, 3)), $urandom);
            else if (pick < 95)
                send_word(ACT_CLEAR, STREAM_W'($urandom_range(0, 3)), $urandom);
            else if (pick < 97)
                send_word(ACT_RESERVED, STREAM_W'($urandom_range(0, 3)), $urandom);
            else
                send_word(ACT_PACKET, STREAM_UNUSED, $urandom);
        end
    endtask

    initial begin
        cfg_max_gap = MAX_GAP_RST;
        cfg_window  = WINDOW_MS_RST;
        wipe_stats();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_gap_kinds();
        test_register_extremes();
        test_window_latch();
        test_random_traffic(300, 32'd16, 16'd4, 1'b1);
        test_random_traffic(300, 32'd1, 16'd1, 1'b1);
        test_random_traffic(300, $urandom_range(2, 64), RATE_W'($urandom_range(2, 20)), 1'b1);
        test_random_traffic(250, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        test_random_traffic(300, $urandom, RATE_W'($urandom_range(1, 300)), 1'b1);
        test_random_traffic(300, 32'd40, 16'd3, 1'b0);
        settle(20);

        if (stats_due.size() != 0)
            flag_error($sformatf("%0d result words never arrived", stats_due.size()));
        $display("ran %0d words in, %0d results out, %0d rate windows closed, %0d errors",
                 n_words, n_results, n_closes, n_errors);
        $display("gap kinds first %0d in-order %0d loss %0d regress %0d resync %0d none %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
                 kind_hits[5]);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plrm_pkg.sv
rtl/plrm_cfg.sv
rtl/plrm_win.sv
rtl/plrm_stats.sv
rtl/packet_loss_and_rate_monitor_core.sv
verif/tb_packet_loss_and_rate_monitor_core.sv
